@@ hw/rtl/bffa_pkg.sv @@
// bffa_pkg: shared codes, register defaults and struct types of the bucket allocator
// no dependencies; imported by every rtl module of the block but bffa_ram, and by its checker
package bffa_pkg;

    // operation codes carried in the input item
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_REMOVE = 2'd2;

    // configuration register map (index taken from paddr[2])
    localparam int         APB_ADDR_W   = 3;
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic       REG_GROWTH   = 1'b1;

    localparam logic [7:0] CAPACITY_RESET = 8'd32;
    localparam logic [4:0] GROWTH_RESET   = 5'd4;
    localparam logic [4:0] GROWTH_MAX     = 5'd16;

    // effective configuration as seen by the controller
    typedef struct packed {
        logic [7:0] capacity;   // never zero
        logic [4:0] growth;     // 1 to 16
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [13:0] total;
        logic [5:0]  fill;
        logic [5:0]  assigned;
        logic [1:0]  status;
    } res_t;

endpackage

@@ hw/rtl/bffa_ram.sv @@
// bffa_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bffa_regs.sv @@
// bffa_regs: apb configuration registers (bucket capacity, growth step)
// depends on bffa_pkg; hands the clamped values to the controller as a cfg_t
module bffa_regs
    import bffa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [7:0] capacity_reg;
    logic [4:0] growth_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            growth_reg   <= GROWTH_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_CAPACITY)
            begin
                capacity_reg <= pwdata[7:0];
            end
            else
            begin
                growth_reg <= pwdata[4:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_GROWTH)
        begin
            prdata = {27'd0, growth_reg};
        end
        else
        begin
            prdata = {24'd0, capacity_reg};
        end
    end

    // zero capacity acts as one, growth clamps to 1..16
    always_comb
    begin
        cfg.capacity = (capacity_reg == 8'd0) ? 8'd1 : capacity_reg;
        if (growth_reg == 5'd0)
        begin
            cfg.growth = 5'd1;
        end
        else if (growth_reg inside {[5'd17:5'd31]})
        begin
            cfg.growth = GROWTH_MAX;
        end
        else
        begin
            cfg.growth = growth_reg;
        end
    end

endmodule

@@ hw/rtl/bffa_ctrl.sv @@
// bffa_ctrl: allocation sequencer around the occupancy ram (read, modify, write back)
// depends on bffa_pkg and bffa_ram
module bffa_ctrl
    import bffa_pkg::*;
#(
    parameter int MAX_BUCKETS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [5:0] bucket_id,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res
);

    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int CW = $clog2(MAX_BUCKETS + 1);
    localparam int SW = ((CW > 5) ? CW : 5) + 1;
    localparam int XW = (CW > 6) ? CW : 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_CHK,
        S_ADD_WR,
        S_SEEK,
        S_CLEAR,
        S_RM_CHK,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] open_reg;
    logic [AW-1:0] fill_reg;
    logic [13:0]   total_reg;
    logic [AW-1:0] cp_reg;
    logic [CW-1:0] scan_reg;
    logic          pend_reg;
    logic [AW-1:0] pidx_reg;
    logic [AW-1:0] clr_reg;
    logic [7:0]    occ_reg;
    logic [5:0]    bid_reg;
    logic          post_reg;
    logic [1:0]    status_reg;
    logic [5:0]    assigned_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [SW-1:0] grown_sum;
    logic [CW-1:0] grown_open;
    logic          can_grow;
    logic [CW-1:0] seek_start;
    logic          seek_hit;
    logic          seek_more;
    logic [7:0]    occ_inc;
    logic          clr_last;
    logic          rm_ok;
    logic          bid_open;
    logic [CW-1:0] cp_inc;

    bffa_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BUCKETS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // growth: open up to cfg.growth buckets, capped at the table size
    assign grown_sum  = SW'(open_reg) + SW'(cfg.growth);
    assign grown_open = (grown_sum > SW'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : CW'(grown_sum);
    assign can_grow   = open_reg < CW'(MAX_BUCKETS);

    assign seek_start = CW'(fill_reg) + CW'(1);
    assign seek_hit   = pend_reg && (ram_rdata < cfg.capacity);
    assign seek_more  = scan_reg < open_reg;
    assign occ_inc    = occ_reg + 8'd1;
    assign clr_last   = (CW'(clr_reg) + CW'(1)) == open_reg;
    assign rm_ok      = ram_rdata != 8'd0;
    assign bid_open   = XW'(bucket_id) < XW'(open_reg);
    assign cp_inc     = CW'(cp_reg) + CW'(1);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  ram_raddr = (opcode == OP_REMOVE) ? AW'(bucket_id) : fill_reg;
            S_SEEK:  ram_raddr = AW'(scan_reg);
            default: ram_raddr = fill_reg;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg;
        ram_wdata = occ_inc;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
            end
            S_ADD_WR:
            begin
                ram_we    = 1'b1;
            end
            S_RM_CHK:
            begin
                ram_we    = rm_ok;
                ram_waddr = AW'(bid_reg);
                ram_wdata = ram_rdata - 8'd1;
            end
            default:
            begin
                ram_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            open_reg     <= '0;
            fill_reg     <= '0;
            total_reg    <= '0;
            cp_reg       <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            pidx_reg     <= '0;
            clr_reg      <= '0;
            occ_reg      <= '0;
            bid_reg      <= '0;
            post_reg     <= 1'b0;
            status_reg   <= ST_OK;
            assigned_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        bid_reg      <= bucket_id;
                        status_reg   <= ST_OK;
                        assigned_reg <= '0;
                        post_reg     <= 1'b0;
                        case (opcode)
                            OP_ADD:
                            begin
                                if (open_reg == '0)
                                begin
                                    // first add opens the first group
                                    fill_reg  <= AW'(open_reg);
                                    clr_reg   <= AW'(open_reg);
                                    open_reg  <= grown_open;
                                    state_reg <= S_CLEAR;
                                end
                                else
                                begin
                                    state_reg <= S_ADD_CHK;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (bid_open)
                                begin
                                    state_reg <= S_RM_CHK;
                                end
                                else
                                begin
                                    status_reg <= ST_BAD_REMOVE;
                                    state_reg  <= S_DONE;
                                end
                            end
                            OP_ADVANCE:
                            begin
                                cp_reg       <= (cp_inc >= open_reg) ? '0 : AW'(cp_inc);
                                assigned_reg <= (cp_inc >= open_reg) ? 6'd0 : 6'(cp_inc);
                                state_reg    <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ADD_CHK:
                begin
                    if (ram_rdata < cfg.capacity)
                    begin
                        occ_reg   <= ram_rdata;
                        state_reg <= S_ADD_WR;
                    end
                    else
                    begin
                        // fill bucket already full: seek before the add
                        scan_reg  <= seek_start;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SEEK;
                    end
                end
                S_ADD_WR:
                begin
                    total_reg    <= total_reg + 14'd1;
                    assigned_reg <= 6'(fill_reg);
                    if (occ_inc >= cfg.capacity)
                    begin
                        post_reg  <= 1'b1;
                        scan_reg  <= seek_start;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SEEK;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SEEK:
                begin
                    // one read issued per cycle, compared in the cycle after it is issued
                    if (seek_hit)
                    begin
                        fill_reg  <= pidx_reg;
                        occ_reg   <= ram_rdata;
                        state_reg <= post_reg ? S_DONE : S_ADD_WR;
                    end
                    else if (seek_more)
                    begin
                        pend_reg <= 1'b1;
                        pidx_reg <= AW'(scan_reg);
                        scan_reg <= scan_reg + CW'(1);
                    end
                    else if (can_grow)
                    begin
                        fill_reg  <= AW'(open_reg);
                        clr_reg   <= AW'(open_reg);
                        open_reg  <= grown_open;
                        state_reg <= S_CLEAR;
                    end
                    else
                    begin
                        if (!post_reg)
                        begin
                            status_reg <= ST_FULL;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_CLEAR:
                begin
                    // zero the newly opened buckets, one per cycle
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_last)
                    begin
                        occ_reg   <= 8'd0;
                        state_reg <= post_reg ? S_DONE : S_ADD_WR;
                    end
                end
                S_RM_CHK:
                begin
                    if (rm_ok)
                    begin
                        total_reg <= total_reg - 14'd1;
                        if (XW'(bid_reg) < XW'(fill_reg))
                        begin
                            fill_reg <= AW'(bid_reg);
                        end
                    end
                    else
                    begin
                        status_reg <= ST_BAD_REMOVE;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = state_reg == S_IDLE;
    assign res_valid    = state_reg == S_DONE;
    assign res.status   = status_reg;
    assign res.assigned = assigned_reg;
    assign res.fill     = 6'(fill_reg);
    assign res.total    = total_reg;

endmodule

@@ hw/rtl/bucket_first_fit_allocator_unit.sv @@
// bucket_first_fit_allocator_unit: top level of the first-fit bucket allocator
// depends on bffa_pkg, bffa_regs, bffa_ctrl (with bffa_ram inside)
//
// from input accept to m_tvalid an item passes the sequencer states, then the output register:
//   advance, unknown opcode and out-of-range remove go straight to done; a remove reads its bucket first;
//   an add that leaves room in its bucket reads and writes back the fill bucket; an add that meets or
//   fills a full bucket adds a seek of one read per bucket scanned, and growth clears each bucket opened
// one item in flight at a time; the occupancy ram's single read port sets the pace
// rst_n is asynchronous, active low; buckets are zeroed as groups open, not at reset
module bucket_first_fit_allocator_unit
    import bffa_pkg::*;
#(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input item
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [5:0] bucket_id, [7:6] zero
    input  logic [1:0]            s_tuser,   // [1:0] opcode
    // result item
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [5:0] assigned_bucket, [11:6] fill_bucket,
                                             // [25:12] connection_total, [31:26] zero
    output logic [1:0]            m_tuser,   // [1:0] status
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t cfg;
    res_t res;
    logic res_valid;
    logic res_ready;

    // output register: parts the sequencer from the downstream stall
    logic out_valid_reg;
    res_t out_reg;

    bffa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bffa_ctrl #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .bucket_id (s_tdata[5:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // a new result may load while the previous one is taken in the same cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0, out_reg.total, out_reg.fill, out_reg.assigned};

endmodule

@@ hw/rtl/bffa_checker.sv @@
// bffa_checker: port-level assertions for the bucket allocator, bound to the top level
// depends on bffa_pkg and bucket_first_fit_allocator_unit
module bffa_checker
    import bffa_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [31:0]           m_tdata,
    input logic [1:0]            m_tuser
);

    // one item at a time: ready drops after every accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // failed operations never hand out a bucket
    a_fail_no_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[5:0] == 6'd0))
        else $error("failed operation reports a bucket");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind bucket_first_fit_allocator_unit bffa_checker u_bffa_checker (.*);
